@@ rtl/ordered_list_engine_assert.svh @@
// ----------------------------------------------------------------------------
// ordered_list_engine_assert
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// clocked check, masked while reset is asserted
`define OLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define OLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/ole_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_pkg
// Types and constants shared by the ordered list engine, its cells and checker.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LEN_W    = 5;
    localparam int STAT_W   = 3;
    localparam int ACT_W    = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_DUMP   = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_ELEMENT   = 3'd3,
        STAT_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } t_cell_op;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_cell_op          op;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] wrap;
    } t_cell_ctl;

    // handed from each cell to its right neighbor
    typedef struct packed {
        logic hit;
        logic first;
    } t_link;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage

`default_nettype wire

@@ rtl/ole_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: compares against the search key and shifts with neighbors.
// ----------------------------------------------------------------------------
module ole_cell import ole_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic              i_we,
    input  logic              i_occ,
    input  logic              i_tail,
    input  logic [DATA_W-1:0] i_prev_data,
    input  logic [DATA_W-1:0] i_next_data,
    input  t_link             i_link,
    output logic [DATA_W-1:0] o_data,
    output t_link             o_link
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_match;

    assign w_match      = i_occ && (r_data == i_ctl.key);
    assign o_link.hit   = i_link.hit | w_match;
    assign o_link.first = w_match & ~i_link.hit;
    assign o_data       = r_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            OP_INSERT: begin
                // first match sits just left of here: new value lands here
                if (i_link.first) begin
                    n_data = i_ctl.val;
                end else if (i_link.hit) begin
                    n_data = i_prev_data;
                end
            end
            OP_REMOVE: begin
                if (i_link.hit || w_match) begin
                    n_data = i_next_data;
                end
            end
            OP_ROTATE: begin
                n_data = i_tail ? i_ctl.wrap : i_next_data;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ordered_list_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values kept in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// For push, insert-after and remove every cell compares its entry with the key
// at once, the first match is found along the cell row and the row shifts in
// the same clock, and the single result is registered. A new request is
// accepted once the result register is empty or being drained, so these run
// at one per cycle when the consumer keeps up. A dump of an empty list answers
// in its request cycle like the others; a dump of n entries uses the request
// cycle and then, while the consumer keeps up, streams one entry per cycle
// from the front cell as the row rotates; no request is accepted until its
// last result is in the output register. No clearing pass follows reset; the
// list is simply empty.
module ordered_list_engine import ole_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // anchor[31:0], value[63:32]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status[2:0], element[34:3], length[39:35]
    output logic        m_axis_tlast
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_rem, n_rem;

    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [DATA_W-1:0] r_out_elem, n_out_elem;
    logic [LEN_W-1:0]  r_out_len, n_out_len;
    logic              r_out_last, n_out_last;

    t_action           w_action;
    logic [DATA_W-1:0] w_anchor, w_value;
    logic              w_out_free, w_accept, w_dump_step;
    logic              w_full, w_found, w_we;
    t_cell_ctl         w_ctl;

    logic [DATA_W-1:0] w_data [CAPACITY];
    t_link             w_link [CAPACITY+1];
    logic [CAPACITY-1:0] w_occ, w_tail;

    assign w_action = t_action'(s_axis_tuser);
    assign w_anchor = s_axis_tdata[31:0];
    assign w_value  = s_axis_tdata[63:32];

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_found    = w_link[CAPACITY].hit;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_action == ACT_DUMP && r_count != '0) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (w_dump_step && r_rem == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_dump_step   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = w_out_free;
            end
            ST_DUMP: begin
                w_dump_step = w_out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // ---------------- cell control ----------------
    always_comb begin
        w_ctl.key  = (w_action == ACT_INSERT) ? w_anchor : w_value;
        w_ctl.val  = w_value;
        w_ctl.wrap = w_data[0];
        w_ctl.op   = OP_HOLD;
        w_link[0]  = '{hit: 1'b0, first: 1'b0};
        w_we       = 1'b0;
        if (r_state == ST_DUMP) begin
            w_ctl.op = OP_ROTATE;
            w_we     = w_dump_step;
        end else begin
            case (w_action)
                ACT_PUSH: begin
                    // push acts as an insert after a virtual slot left of the row
                    w_ctl.op  = OP_INSERT;
                    w_link[0] = '{hit: 1'b1, first: 1'b1};
                    w_we      = w_accept && !w_full;
                end
                ACT_INSERT: begin
                    w_ctl.op = OP_INSERT;
                    w_we     = w_accept && !w_full && w_found;
                end
                ACT_REMOVE: begin
                    w_ctl.op = OP_REMOVE;
                    w_we     = w_accept && w_found;
                end
                default: begin
                    w_ctl.op = OP_HOLD;
                end
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_prev, w_next;

        assign w_occ[g]  = CNT_W'(g) < r_count;
        assign w_tail[g] = (r_count == CNT_W'(g + 1));

        if (g == 0) begin : g_front
            assign w_prev = w_value;
        end else begin : g_mid
            assign w_prev = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_back
            assign w_next = w_data[0];
        end else begin : g_inner
            assign w_next = w_data[g+1];
        end

        ole_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_we        (w_we),
            .i_occ       (w_occ[g]),
            .i_tail      (w_tail[g]),
            .i_prev_data (w_prev),
            .i_next_data (w_next),
            .i_link      (w_link[g]),
            .o_data      (w_data[g]),
            .o_link      (w_link[g+1])
        );
    end

    // ---------------- count, dump counter, result register ----------------
    always_comb begin
        n_count      = r_count;
        n_rem        = r_rem;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_elem   = r_out_elem;
        n_out_len    = r_out_len;
        n_out_last   = r_out_last;

        if (w_dump_step) begin
            n_rem        = r_rem - CNT_W'(1);
            n_out_valid  = 1'b1;
            n_out_status = STAT_ELEMENT;
            n_out_elem   = w_data[0];
            n_out_len    = LEN_W'(r_count);
            n_out_last   = (r_rem == CNT_W'(1));
        end else if (w_accept) begin
            n_out_valid = 1'b1;
            n_out_elem  = '0;
            n_out_last  = 1'b1;
            case (w_action)
                ACT_PUSH: begin
                    n_out_status = w_full ? STAT_FULL : STAT_DONE;
                    if (!w_full) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                ACT_INSERT: begin
                    if (w_full) begin
                        n_out_status = STAT_FULL;
                    end else if (w_found) begin
                        n_out_status = STAT_DONE;
                        n_count      = r_count + CNT_W'(1);
                    end else begin
                        n_out_status = STAT_NOT_FOUND;
                    end
                end
                ACT_REMOVE: begin
                    if (w_found) begin
                        n_out_status = STAT_DONE;
                        n_count      = r_count - CNT_W'(1);
                    end else begin
                        n_out_status = STAT_NOT_FOUND;
                    end
                end
                default: begin
                    n_rem = r_count;
                    if (r_count == '0) begin
                        n_out_status = STAT_EMPTY;
                    end else begin
                        n_out_valid = r_out_valid && !m_axis_tready;
                    end
                end
            endcase
            n_out_len = LEN_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_elem   <= n_out_elem;
        r_out_len    <= n_out_len;
        r_out_last   <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_len, r_out_elem, r_out_status};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/ole_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_checker
// Port-level checks for the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_list_engine_assert.svh"

module ole_checker import ole_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,   // status[2:0], element[34:3], length[39:35]
    input wire logic        m_axis_tlast
);

    logic              w_is_elem;
    logic              w_stall;
    logic [DATA_W-1:0] w_elem;
    logic [40:0]       w_out_word;

    assign w_is_elem  = (m_axis_tdata[2:0] == STAT_ELEMENT);
    assign w_stall    = m_axis_tvalid && !m_axis_tready;
    assign w_elem     = m_axis_tdata[34:3];
    assign w_out_word = {m_axis_tlast, m_axis_tdata};

    `OLE_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // element is only carried by dump results
    `OLE_ASSERT(a_elem_zero, m_axis_tvalid && !w_is_elem |-> w_elem == '0, "element not zero")

    // only a dump run produces a result without the last marker
    `OLE_ASSERT(a_run_is_dump, m_axis_tvalid && !m_axis_tlast |-> w_is_elem, "open run not a dump")

    `OLE_ASSERT(a_out_hold, w_stall |=> m_axis_tvalid && $stable(w_out_word), "stalled result changed")

endmodule

bind ordered_list_engine ole_checker u_ole_checker (.*);

`default_nettype wire
